// ===== hdl/erl_pkg.sv =====
// ----------------------------------------------------------------------------
// erl_pkg
// Shared constants, types and the control program of the record log block.
// ----------------------------------------------------------------------------
package erl_pkg;

    // store geometry
    localparam int STORE_BYTES   = 1024;
    localparam int RECORD_BYTES  = 16;
    localparam int HEADER_OFFSET = 0;

    // derived widths
    localparam int ADDR_W    = $clog2(STORE_BYTES);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int EA_W      = ADDR_W + 2;
    localparam int REC_IDX_W = $clog2(RECORD_BYTES);

    // fixed field widths
    localparam int CMD_W  = 2;
    localparam int OFF_W  = 4;
    localparam int BYTE_W = 8;
    localparam int BASE_W = 10;

    localparam bit HDR_IN_REC = (HEADER_OFFSET < RECORD_BYTES);

    localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] MARK_BYTE   = 8'h01;

    // command codes
    localparam logic [CMD_W-1:0] CMD_STORE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMMIT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_BOOT   = 2'd3;

    // program steps
    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_STORE,
        S_READ,
        S_CM0,
        S_CM1,
        S_WCLR,
        S_WHDR,
        S_WREC,
        S_DONE,
        S_BT0,
        S_BT1,
        S_BT2,
        S_BT3,
        S_LD0,
        S_LD1
    } step_t;

    typedef enum logic [1:0] {MEM_NONE, MEM_READ, MEM_WRITE} mem_op_t;
    typedef enum logic [1:0] {A_SWEEP, A_SCAN, A_REC, A_HDR} addr_sel_t;
    typedef enum logic [1:0] {W_ERASED, W_ZERO, W_ONE, W_WORK} wdat_sel_t;
    typedef enum logic [1:0] {CNT_HOLD, CNT_CLEAR, CNT_INC} cnt_op_t;
    typedef enum logic [1:0] {POS_HOLD, POS_CLEAR, POS_STEP} pos_op_t;
    typedef enum logic [1:0] {SLOT_HOLD, SLOT_CLEAR, SLOT_FROM_POS, SLOT_ADVANCE} slot_op_t;
    typedef enum logic [1:0] {WK_NONE, WK_STORE, WK_LOAD, WK_MARK} work_op_t;
    typedef enum logic [1:0] {RD_HOLD, RD_CLEAR, RD_LOAD} rd_op_t;
    typedef enum logic [1:0] {WRAP_HOLD, WRAP_CLEAR, WRAP_SET} wrap_op_t;
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_DISPATCH,
        C_SWEEP_MORE,
        C_REC_MORE,
        C_REC_END,
        C_NO_WRAP,
        C_SCAN_END_OR_HDR
    } cond_t;

    // one control word
    typedef struct packed {
        logic      take;
        logic      done;
        mem_op_t   mem_op;
        addr_sel_t addr_sel;
        wdat_sel_t wdat_sel;
        cnt_op_t   cnt_op;
        pos_op_t   pos_op;
        slot_op_t  slot_op;
        work_op_t  work_op;
        rd_op_t    rd_op;
        wrap_op_t  wrap_op;
        cond_t     cond;
        logic      alt;
        step_t     target;
    } ctl_t;

    // datapath flags for the jump conditions
    typedef struct packed {
        logic sweep_more;
        logic rec_more;
        logic rec_end;
        logic no_wrap;
        logic scan_end;
        logic hdr_zero;
    } stat_t;

    // control program
    function automatic ctl_t rom_word(step_t s);
        ctl_t w;
        w = '{take: 1'b0, done: 1'b0, mem_op: MEM_NONE, addr_sel: A_SWEEP,
              wdat_sel: W_ZERO, cnt_op: CNT_HOLD, pos_op: POS_HOLD,
              slot_op: SLOT_HOLD, work_op: WK_NONE, rd_op: RD_HOLD,
              wrap_op: WRAP_HOLD, cond: C_NEXT, alt: 1'b0, target: S_IDLE};
        unique case (s)
            S_CLR:
            begin
                w.mem_op   = MEM_WRITE;
                w.addr_sel = A_SWEEP;
                w.wdat_sel = W_ERASED;
                w.cnt_op   = CNT_INC;
                w.cond     = C_SWEEP_MORE;
                w.target   = S_CLR;
            end
            S_IDLE:
            begin
                w.take    = 1'b1;
                w.cnt_op  = CNT_CLEAR;
                w.rd_op   = RD_CLEAR;
                w.wrap_op = WRAP_CLEAR;
                w.cond    = C_DISPATCH;
            end
            S_STORE:
            begin
                w.work_op = WK_STORE;
                w.cond    = C_ALWAYS;
                w.target  = S_DONE;
            end
            S_READ:
            begin
                w.rd_op  = RD_LOAD;
                w.cond   = C_ALWAYS;
                w.target = S_DONE;
            end
            S_CM0:
            begin
                w.work_op = WK_MARK;
                w.slot_op = SLOT_ADVANCE;
            end
            S_CM1:
            begin
                w.cond   = C_NO_WRAP;
                w.target = S_WREC;
            end
            S_WCLR:
            begin
                w.mem_op   = MEM_WRITE;
                w.addr_sel = A_SWEEP;
                w.wdat_sel = W_ZERO;
                w.cnt_op   = CNT_INC;
                w.slot_op  = SLOT_CLEAR;
                w.wrap_op  = WRAP_SET;
                w.cond     = C_SWEEP_MORE;
                w.target   = S_WCLR;
            end
            S_WHDR:
            begin
                w.mem_op   = MEM_WRITE;
                w.addr_sel = A_HDR;
                w.wdat_sel = W_ONE;
                w.cnt_op   = CNT_CLEAR;
            end
            S_WREC:
            begin
                w.mem_op   = MEM_WRITE;
                w.addr_sel = A_REC;
                w.wdat_sel = W_WORK;
                w.cnt_op   = CNT_INC;
                w.cond     = C_REC_MORE;
                w.target   = S_WREC;
            end
            S_DONE:
            begin
                w.done   = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
            S_BT0:
            begin
                w.slot_op = SLOT_CLEAR;
                w.pos_op  = POS_CLEAR;
            end
            S_BT1:
            begin
                w.mem_op   = MEM_READ;
                w.addr_sel = A_SCAN;
                w.cond     = C_SCAN_END_OR_HDR;
                w.alt      = 1'b0;
                w.target   = S_LD0;
            end
            S_BT2:
            begin
                w.cond   = C_SCAN_END_OR_HDR;
                w.alt    = 1'b1;
                w.target = S_LD0;
            end
            S_BT3:
            begin
                w.slot_op = SLOT_FROM_POS;
                w.pos_op  = POS_STEP;
                w.cond    = C_ALWAYS;
                w.target  = S_BT1;
            end
            S_LD0:
            begin
                w.mem_op   = MEM_READ;
                w.addr_sel = A_REC;
                w.cond     = C_REC_END;
                w.target   = S_DONE;
            end
            S_LD1:
            begin
                w.work_op = WK_LOAD;
                w.cnt_op  = CNT_INC;
                w.cond    = C_ALWAYS;
                w.target  = S_LD0;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

    // first step of each command
    function automatic step_t entry_step(logic [CMD_W-1:0] c);
        step_t s;
        unique case (c)
            CMD_STORE:  s = S_STORE;
            CMD_READ:   s = S_READ;
            CMD_COMMIT: s = S_CM0;
            CMD_BOOT:   s = S_BT0;
            default:    s = S_IDLE;
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/erl_if.sv =====
// ----------------------------------------------------------------------------
// erl_if
// Valid/ready channels for requests into and results out of the record log.
// ----------------------------------------------------------------------------

// request channel
interface erl_req_if
    import erl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [OFF_W-1:0]  entry_offset;
    logic [BYTE_W-1:0] entry_value;

    modport source (output valid, output command, output entry_offset,
                    output entry_value, input ready);
    modport sink (input valid, input command, input entry_offset,
                  input entry_value, output ready);
endinterface

// result channel
interface erl_rsp_if
    import erl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;
    logic [BASE_W-1:0] record_base;
    logic              wrapped;

    modport source (output valid, output read_data, output record_base,
                    output wrapped, input ready);
    modport sink (input valid, input read_data, input record_base,
                  input wrapped, output ready);
endinterface

// ===== hdl/erl_sequencer.sv =====
// ----------------------------------------------------------------------------
// erl_sequencer
// Step counter over the control program, with conditional jumps and dispatch.
// ----------------------------------------------------------------------------
module erl_sequencer
    import erl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  stat_t            stat,
    input  logic             req_valid,
    input  logic [CMD_W-1:0] command,
    input  logic             out_busy,
    output ctl_t             ctl,
    output logic             accept,
    output logic             emit
);

    step_t step_reg;
    step_t step_next;
    logic  stall;
    logic  take_jump;

    // control word of the current step
    always_comb
    begin
        ctl    = rom_word(step_reg);
        accept = ctl.take && req_valid;
        stall  = ctl.done && out_busy;
        emit   = ctl.done && !out_busy;
    end

    // jump condition select
    always_comb
    begin
        case (ctl.cond)
            C_SWEEP_MORE:      take_jump = stat.sweep_more;
            C_REC_MORE:        take_jump = stat.rec_more;
            C_REC_END:         take_jump = stat.rec_end;
            C_NO_WRAP:         take_jump = stat.no_wrap;
            C_SCAN_END_OR_HDR: take_jump = ctl.alt ? stat.hdr_zero : stat.scan_end;
            C_ALWAYS:          take_jump = 1'b1;
            default:           take_jump = 1'b0;
        endcase
    end

    // next step
    always_comb
    begin
        if (stall)
        begin
            step_next = step_reg;
        end
        else if (ctl.cond == C_DISPATCH)
        begin
            step_next = accept ? entry_step(command) : step_reg;
        end
        else if (take_jump)
        begin
            step_next = ctl.target;
        end
        else
        begin
            step_next = step_t'(step_reg + 4'd1);
        end
    end

    // step counter, starts with the erase sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_CLR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== hdl/erl_datapath.sv =====
// ----------------------------------------------------------------------------
// erl_datapath
// Nonvolatile byte store, working record, counters and slot pointer.
// ----------------------------------------------------------------------------
module erl_datapath
    import erl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_t              ctl,
    input  logic              accept,
    input  logic [OFF_W-1:0]  entry_offset,
    input  logic [BYTE_W-1:0] entry_value,
    output stat_t             stat,
    output logic [BYTE_W-1:0] rd_data,
    output logic [CNT_W-1:0]  slot_base,
    output logic              wrap_flag
);

    logic [BYTE_W-1:0] nv_mem [STORE_BYTES];
    logic [BYTE_W-1:0] work_reg [RECORD_BYTES];

    logic [BYTE_W-1:0] rdata_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [BYTE_W-1:0] val_reg;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  slot_reg, slot_next;
    logic [BYTE_W-1:0] rd_reg, rd_next;
    logic              wrap_reg, wrap_next;

    logic [EA_W-1:0]      nv_addr;
    logic                 nv_ok;
    logic [ADDR_W-1:0]    nv_idx;
    logic [BYTE_W-1:0]    nv_wdata;
    logic                 off_ok;
    logic [REC_IDX_W-1:0] off_idx;
    logic [REC_IDX_W-1:0] cnt_idx;
    logic [REC_IDX_W-1:0] work_rd_idx;
    logic [BYTE_W-1:0]    work_rd;
    logic                 work_we;
    logic [REC_IDX_W-1:0] work_widx;
    logic [BYTE_W-1:0]    work_wdata;

    // request fields held for the command steps
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            off_reg <= entry_offset;
            val_reg <= entry_value;
        end
    end

    assign off_ok  = (32'(off_reg) < RECORD_BYTES);
    assign off_idx = REC_IDX_W'(off_reg);
    assign cnt_idx = REC_IDX_W'(cnt_reg);

    // store address and write data
    always_comb
    begin
        case (ctl.addr_sel)
            A_SCAN:  nv_addr = EA_W'(pos_reg) + EA_W'(HEADER_OFFSET);
            A_REC:   nv_addr = EA_W'(slot_reg) + EA_W'(cnt_reg);
            A_HDR:   nv_addr = EA_W'(HEADER_OFFSET);
            default: nv_addr = EA_W'(cnt_reg);
        endcase
        nv_ok  = (nv_addr < EA_W'(STORE_BYTES));
        nv_idx = nv_addr[ADDR_W-1:0];
        case (ctl.wdat_sel)
            W_ERASED: nv_wdata = ERASED_BYTE;
            W_ONE:    nv_wdata = MARK_BYTE;
            W_WORK:   nv_wdata = work_rd;
            default:  nv_wdata = '0;
        endcase
    end

    // single-port nonvolatile store, out-of-range reads give zero
    always_ff @(posedge clk)
    begin
        if (ctl.mem_op == MEM_WRITE && nv_ok)
        begin
            nv_mem[nv_idx] <= nv_wdata;
        end
        if (ctl.mem_op == MEM_READ)
        begin
            rdata_reg <= nv_ok ? nv_mem[nv_idx] : '0;
        end
    end

    // working record read port
    assign work_rd_idx = (ctl.rd_op == RD_LOAD) ? off_idx : cnt_idx;
    assign work_rd     = work_reg[work_rd_idx];

    // working record write port
    always_comb
    begin
        work_we    = 1'b0;
        work_widx  = cnt_idx;
        work_wdata = rdata_reg;
        case (ctl.work_op)
            WK_STORE:
            begin
                work_we    = off_ok;
                work_widx  = off_idx;
                work_wdata = val_reg;
            end
            WK_LOAD:
            begin
                work_we = 1'b1;
            end
            WK_MARK:
            begin
                work_we    = HDR_IN_REC;
                work_widx  = REC_IDX_W'(HEADER_OFFSET);
                work_wdata = MARK_BYTE;
            end
            default:
            begin
                work_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (work_we)
        begin
            work_reg[work_widx] <= work_wdata;
        end
    end

    // counters, slot pointer and result bits
    always_comb
    begin
        case (ctl.cnt_op)
            CNT_CLEAR: cnt_next = '0;
            CNT_INC:   cnt_next = cnt_reg + CNT_W'(1);
            default:   cnt_next = cnt_reg;
        endcase
        case (ctl.pos_op)
            POS_CLEAR: pos_next = '0;
            POS_STEP:  pos_next = pos_reg + CNT_W'(RECORD_BYTES);
            default:   pos_next = pos_reg;
        endcase
        case (ctl.slot_op)
            SLOT_CLEAR:    slot_next = '0;
            SLOT_FROM_POS: slot_next = pos_reg;
            SLOT_ADVANCE:  slot_next = slot_reg + CNT_W'(RECORD_BYTES);
            default:       slot_next = slot_reg;
        endcase
        case (ctl.rd_op)
            RD_CLEAR: rd_next = '0;
            RD_LOAD:  rd_next = off_ok ? work_rd : '0;
            default:  rd_next = rd_reg;
        endcase
        case (ctl.wrap_op)
            WRAP_CLEAR: wrap_next = 1'b0;
            WRAP_SET:   wrap_next = 1'b1;
            default:    wrap_next = wrap_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pos_reg  <= '0;
            slot_reg <= '0;
            rd_reg   <= '0;
            wrap_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            pos_reg  <= pos_next;
            slot_reg <= slot_next;
            rd_reg   <= rd_next;
            wrap_reg <= wrap_next;
        end
    end

    // flags for the sequencer
    always_comb
    begin
        stat.sweep_more = (cnt_reg != CNT_W'(STORE_BYTES - 1));
        stat.rec_more   = (cnt_reg != CNT_W'(RECORD_BYTES - 1));
        stat.rec_end    = (cnt_reg == CNT_W'(RECORD_BYTES));
        stat.no_wrap    = ((EA_W'(slot_reg) + EA_W'(RECORD_BYTES)) <= EA_W'(STORE_BYTES));
        stat.scan_end   = (pos_reg >= CNT_W'(STORE_BYTES));
        stat.hdr_zero   = (rdata_reg == '0);
    end

    assign rd_data   = rd_reg;
    assign slot_base = slot_reg;
    assign wrap_flag = wrap_reg;

endmodule

// ===== hdl/eeprom_record_log_wear_leveler.sv =====
// ----------------------------------------------------------------------------
// eeprom_record_log_wear_leveler
// Store and read go from the request step through one command step to done;
// commit has two setup steps, one write per record byte, then done.
// A wrapping commit first zeroes the store and writes the header.
// Boot scans slot headers, then loads the record of the last used slot.
// Next request is taken in the cycle after the result is registered; a held
// result stalls the done step. After reset a sweep erases the store to 0xFF.
// ----------------------------------------------------------------------------
module eeprom_record_log_wear_leveler
    import erl_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    erl_req_if.sink  request,
    erl_rsp_if.source result
);

    ctl_t              ctl;
    stat_t             stat;
    logic              accept;
    logic              emit;
    logic              out_busy;
    logic [BYTE_W-1:0] rd_data;
    logic [CNT_W-1:0]  slot_base;
    logic              wrap_flag;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] read_data_reg;
    logic [BASE_W-1:0] base_reg;
    logic              wrapped_reg;

    assign out_busy      = out_valid_reg && !result.ready;
    assign request.ready = ctl.take;

    erl_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .req_valid (request.valid),
        .command   (request.command),
        .out_busy  (out_busy),
        .ctl       (ctl),
        .accept    (accept),
        .emit      (emit)
    );

    erl_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .accept       (accept),
        .entry_offset (request.entry_offset),
        .entry_value  (request.entry_value),
        .stat         (stat),
        .rd_data      (rd_data),
        .slot_base    (slot_base),
        .wrap_flag    (wrap_flag)
    );

    // result register
    assign out_valid_next = emit || out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            read_data_reg <= rd_data;
            base_reg      <= BASE_W'(slot_base);
            wrapped_reg   <= wrap_flag;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.read_data   = read_data_reg;
    assign result.record_base = base_reg;
    assign result.wrapped     = wrapped_reg;

`ifndef SYNTHESIS
    // a wrap always leaves the log at slot zero
    a_wrap_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.wrapped |-> result.record_base == '0)
        else $error("wrapped result with nonzero record base");

    // the reported slot always fits inside the store
    a_slot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (EA_W'(slot_base) + EA_W'(RECORD_BYTES)) <= EA_W'(STORE_BYTES))
        else $error("slot base past end of store");

    // a finished command shows up on the result channel
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> result.valid)
        else $error("finished command not presented");
`endif

endmodule
